FILE: src/ordered_array_list_macros.svh
// Assertion macros for the ordered array list block.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef ORDERED_ARRAY_LIST_MACROS_SVH
`define ORDERED_ARRAY_LIST_MACROS_SVH

// Checked only outside reset.
`define OAL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ordered_array_list assertion failed");

// Checked at every edge, reset included.
`define OAL_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("ordered_array_list assertion failed");

`endif

FILE: src/oal_pkg.sv
// Package for the ordered array list: request and response types, codes.
// No dependencies.
`default_nettype none

package oal_pkg;

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_FIND   = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BADPOS   = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic        [2:0]  operation;
        logic        [4:0]  position;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic        [1:0]  status;
        logic signed [31:0] data_out;
        logic        [4:0]  found_position;
        logic        [4:0]  length_out;
    } t_rsp;

endpackage

`default_nettype wire

FILE: src/ordered_array_list.sv
// Ordered array list of signed 32-bit values with insert, delete, find, read.
// Uses oal_pkg, oal_ram and ordered_array_list_macros.svh.
//
// Usage:
//   Requests enter on i_in_req with i_in_valid; a request is taken at an edge
//   where i_in_valid is high and o_in_stall is low. Each request yields one
//   response on o_out_rsp with o_out_valid, taken when i_out_stall is low.
//   One request is worked on at a time; o_in_stall is high while a request
//   is in progress or its response waits, so the next request is taken
//   only after the response has been taken.
//   Work per operation, on the single RAM port pair:
//     clear, errors, unused codes: answered from idle without RAM access
//     read:   one RAM read, then the response
//     insert: entries from position to the end move up one place, then write
//     delete: the entry is read, then later entries move down one place
//     find:   entries are scanned from the first until a match or the end
//   Shift and scan loops issue one RAM read a cycle and use it the next.
//   Reset (synchronous, active low) empties the list and drops any pending
//   response; entry storage is not cleared, only entries below the length
//   are ever read. A stalled response holds in the output register.
`default_nettype none

`include "ordered_array_list_macros.svh"

module ordered_array_list #(
    parameter int CAPACITY = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire oal_pkg::t_req i_in_req,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output oal_pkg::t_rsp      o_out_rsp
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 5) ? CW : 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_DEL_RD,
        S_SHIFT,
        S_SCAN
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [2:0]         r_op, n_op;
    logic [4:0]         r_pos, n_pos;
    logic signed [31:0] r_val, n_val;
    logic [IW-1:0]      r_s, n_s;
    logic [CW-1:0]      r_n, n_n;
    logic               r_pend, n_pend;
    logic [IW-1:0]      r_paddr, n_paddr;
    logic signed [31:0] r_data, n_data;
    oal_pkg::t_rsp      r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic signed [31:0] ram_wdata;
    logic [IW-1:0]      ram_raddr;
    logic signed [31:0] ram_rdata;

    logic               accept;
    logic [PW-1:0]      cnt_x, pos_x, pos_m1, rpos_m1;
    logic               bad_pos;

    oal_ram #(
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE) || r_out_valid;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    assign cnt_x   = PW'(r_count);
    assign pos_x   = PW'(i_in_req.position);
    assign pos_m1  = pos_x - PW'(1);
    assign rpos_m1 = PW'(r_pos) - PW'(1);
    assign bad_pos = (pos_x == '0) || (pos_x > cnt_x);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_op        = r_op;
        n_pos       = r_pos;
        n_val       = r_val;
        n_s         = r_s;
        n_n         = r_n;
        n_pend      = 1'b0;
        n_paddr     = r_paddr;
        n_data      = r_data;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        ram_we      = 1'b0;
        ram_waddr   = r_paddr;
        ram_wdata   = ram_rdata;
        ram_raddr   = r_s;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op        = i_in_req.operation;
                    n_pos       = i_in_req.position;
                    n_val       = i_in_req.value;
                    n_out.status         = oal_pkg::ST_OK;
                    n_out.data_out       = '0;
                    n_out.found_position = '0;
                    n_out.length_out     = 5'(r_count);
                    n_out_valid          = 1'b1;
                    unique case (i_in_req.operation)
                        oal_pkg::OP_CLEAR: begin
                            n_count          = '0;
                            n_out.length_out = '0;
                        end
                        oal_pkg::OP_INSERT: begin
                            if (cnt_x == PW'(CAPACITY)) begin
                                n_out.status = oal_pkg::ST_FULL;
                            end else if (pos_x == '0 || pos_x > cnt_x + PW'(1)) begin
                                n_out.status = oal_pkg::ST_BADPOS;
                            end else begin
                                n_out_valid = 1'b0;
                                n_s         = IW'(cnt_x - PW'(1));
                                n_n         = CW'(cnt_x - pos_x + PW'(1));
                                n_state     = S_SHIFT;
                            end
                        end
                        oal_pkg::OP_DELETE: begin
                            if (bad_pos) begin
                                n_out.status = oal_pkg::ST_BADPOS;
                            end else begin
                                n_out_valid = 1'b0;
                                ram_raddr   = pos_m1[IW-1:0];
                                n_s         = IW'(pos_x);
                                n_n         = CW'(cnt_x - pos_x);
                                n_state     = S_DEL_RD;
                            end
                        end
                        oal_pkg::OP_FIND: begin
                            n_out_valid = 1'b0;
                            n_s         = '0;
                            n_n         = r_count;
                            n_state     = S_SCAN;
                        end
                        oal_pkg::OP_READ: begin
                            if (bad_pos) begin
                                n_out.status = oal_pkg::ST_BADPOS;
                            end else begin
                                n_out_valid = 1'b0;
                                ram_raddr   = pos_m1[IW-1:0];
                                n_state     = S_RD_WAIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD_WAIT: begin
                n_out.data_out = ram_rdata;
                n_out_valid    = 1'b1;
                n_state        = S_IDLE;
            end
            S_DEL_RD: begin
                n_data  = ram_rdata;
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_paddr;
                    ram_wdata = ram_rdata;
                end
                if (r_n != '0) begin
                    ram_raddr = r_s;
                    n_pend    = 1'b1;
                    n_n       = r_n - CW'(1);
                    if (r_op == oal_pkg::OP_INSERT) begin
                        n_paddr = r_s + IW'(1);
                        n_s     = r_s - IW'(1);
                    end else begin
                        n_paddr = r_s - IW'(1);
                        n_s     = r_s + IW'(1);
                    end
                end else if (!r_pend) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_op == oal_pkg::OP_INSERT) begin
                        ram_we           = 1'b1;
                        ram_waddr        = rpos_m1[IW-1:0];
                        ram_wdata        = r_val;
                        n_count          = r_count + CW'(1);
                        n_out.data_out   = '0;
                        n_out.length_out = 5'(r_count + CW'(1));
                    end else begin
                        n_count          = r_count - CW'(1);
                        n_out.data_out   = r_data;
                        n_out.length_out = 5'(r_count - CW'(1));
                    end
                end
            end
            S_SCAN: begin
                if (r_pend && ram_rdata == r_val) begin
                    n_out.status         = oal_pkg::ST_OK;
                    n_out.found_position = 5'(PW'(r_paddr) + PW'(1));
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end else if (r_n != '0) begin
                    ram_raddr = r_s;
                    n_pend    = 1'b1;
                    n_paddr   = r_s;
                    n_s       = r_s + IW'(1);
                    n_n       = r_n - CW'(1);
                end else if (!r_pend) begin
                    n_out.status         = oal_pkg::ST_NOTFOUND;
                    n_out.found_position = '0;
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_op    <= n_op;
        r_pos   <= n_pos;
        r_val   <= n_val;
        r_s     <= n_s;
        r_n     <= n_n;
        r_paddr <= n_paddr;
        r_data  <= n_data;
        r_out   <= n_out;
    end

    `OAL_ASSERT(a_count_in_range, (r_count <= CW'(CAPACITY)))
    `OAL_ASSERT_ALWAYS(a_busy_stalls, (r_state != S_IDLE) |-> o_in_stall)
    `OAL_ASSERT(a_scan_no_write, (r_state == S_SCAN) |-> !ram_we)
    `OAL_ASSERT(a_write_in_range, ram_we |-> (PW'(ram_waddr) < PW'(CAPACITY)))
    `OAL_ASSERT(a_done_returns_idle, ($rose(r_out_valid) |-> (r_state == S_IDLE)))

endmodule

`default_nettype wire

FILE: src/oal_ram.sv
// Entry storage for the ordered array list: one write port, one read port,
// registered read data. No dependencies.
`default_nettype none

module oal_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic signed [31:0] i_wdata,
    input  wire logic [AW-1:0]     i_raddr,
    output logic signed [31:0]     o_rdata
);

    logic signed [31:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
